>>> rtl/core/tvg_pkg.sv
// tvg_pkg: shared constants, codes and types of the torus vertex generator
// no dependencies; compiled before every other file
`default_nettype none

package tvg_pkg;

  localparam int MAX_SEGMENTS = 255;
  localparam int ANGLE_BITS   = 16;

  localparam int SEG_W     = 8;
  localparam int RAD_W     = 16;
  localparam int COMP_W    = 32;
  localparam int TEX_FRAC  = 16;
  localparam int TEX_X_W   = TEX_FRAC + 2;
  localparam int TEX_Y_W   = TEX_FRAC + 1;
  localparam int CFG_IDX_W = 2;

  // long division width covers angle and texcoord dividends
  localparam int DIV_W = (SEG_W + ANGLE_BITS > SEG_W + TEX_FRAC + 1) ?
                         SEG_W + ANGLE_BITS : SEG_W + TEX_FRAC + 1;
  localparam int DIV_LANES = 4;

  localparam int Q_W        = 31;
  localparam int SINE_LANES = 4;
  localparam logic [Q_W-1:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [Q_W-1:0] HALF_PI_Q30 = 31'd1686629713;

  // floor(v / k) as (v * m) >> (32 + l), exact for v below 2^32
  localparam int HORNER_STEPS = 5;
  localparam int HMUL_W       = 33;
  localparam logic [HMUL_W-1:0] HORNER_MUL [HORNER_STEPS] = '{
    33'd4997780127, 33'd7635497416, 33'd6544712071, 33'd6871947674, 33'd5726623062
  };
  localparam logic [2:0] HORNER_L [HORNER_STEPS] = '{3'd7, 3'd7, 3'd6, 3'd5, 3'd3};

  localparam int PKT_MAX = 5;
  localparam int CNT_W   = 3;

  localparam logic REQ_QUAD = 1'b1;

  typedef enum logic [2:0] {
    KIND_POSITION,
    KIND_NORMAL,
    KIND_S_TANGENT,
    KIND_T_TANGENT,
    KIND_TEXCOORD,
    KIND_TRIANGLE,
    KIND_ERROR
  } kind_t;

  typedef enum logic [1:0] {
    CAT_VERTEX,
    CAT_QUAD,
    CAT_ERROR
  } cat_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEGMENTS,
    CFG_MAJOR_RADIUS,
    CFG_TUBE_RADIUS
  } cfg_reg_t;

  typedef struct packed {
    cat_t                 cat;
    logic [SEG_W-1:0]     ring;
    logic [SEG_W-1:0]     vert;
    logic [1:0]           qa;
    logic [1:0]           qb;
    logic [TEX_X_W-1:0]   tex_x;
    logic [TEX_Y_W-1:0]   tex_y;
  } side_t;

  typedef logic [DIV_LANES-1:0][SEG_W-1:0]  rem_lanes_t;
  typedef logic [DIV_LANES-1:0][DIV_W-1:0]  w_lanes_t;
  typedef logic [SINE_LANES-1:0][Q_W-1:0]   q30_lanes_t;
  typedef logic [SINE_LANES-1:0][31:0]      sq_lanes_t;

  typedef struct packed {
    kind_t             kind;
    logic [COMP_W-1:0] x;
    logic [COMP_W-1:0] y;
    logic [COMP_W-1:0] z;
  } res_t;

  typedef res_t [PKT_MAX-1:0] res_arr_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    res_arr_t         res;
  } pkt_t;

  function automatic logic [COMP_W-1:0] apply_sign(logic neg, logic [COMP_W-1:0] mag);
    return neg ? (~mag + COMP_W'(1)) : mag;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/tvg_if.sv
// tvg_req_if and tvg_res_if: request and result channels, valid/ready
// depends on tvg_pkg
`default_nettype none

interface tvg_req_if;
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [tvg_pkg::SEG_W-1:0] ring_index;
  logic [tvg_pkg::SEG_W-1:0] vert_index;

  modport source (output valid, req_type, ring_index, vert_index, input ready);
  modport sink   (input valid, req_type, ring_index, vert_index, output ready);
endinterface

interface tvg_res_if;
  logic                             valid;
  logic                             ready;
  logic [2:0]                       kind;
  logic signed [tvg_pkg::COMP_W-1:0] comp_x;
  logic signed [tvg_pkg::COMP_W-1:0] comp_y;
  logic signed [tvg_pkg::COMP_W-1:0] comp_z;
  logic                             last;

  modport source (output valid, kind, comp_x, comp_y, comp_z, last, input ready);
  modport sink   (input valid, kind, comp_x, comp_y, comp_z, last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/tvg_div_cell.sv
// tvg_div_cell: one restoring long-division step on four lanes, registered
// depends on tvg_pkg
`default_nettype none

module tvg_div_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  tvg_pkg::side_t            in_side,
  input  tvg_pkg::rem_lanes_t       in_rem,
  input  tvg_pkg::w_lanes_t         in_w,
  input  logic [tvg_pkg::SEG_W-1:0] divisor,
  output logic                      out_valid,
  output tvg_pkg::side_t            out_side,
  output tvg_pkg::rem_lanes_t       out_rem,
  output tvg_pkg::w_lanes_t         out_w
);

  tvg_pkg::rem_lanes_t rem_next;
  tvg_pkg::w_lanes_t   w_next;

  always_comb begin
    logic [tvg_pkg::SEG_W:0] trial;
    logic [tvg_pkg::SEG_W:0] diff;
    trial = '0;
    diff  = '0;
    for (int i = 0; i < tvg_pkg::DIV_LANES; i++) begin
      trial = {in_rem[i], in_w[i][tvg_pkg::DIV_W-1]};
      diff  = trial - {1'b0, divisor};
      if (trial >= {1'b0, divisor}) begin
        rem_next[i] = diff[tvg_pkg::SEG_W-1:0];
        w_next[i]   = {in_w[i][tvg_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_next[i] = trial[tvg_pkg::SEG_W-1:0];
        w_next[i]   = {in_w[i][tvg_pkg::DIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= in_side;
      out_rem  <= rem_next;
      out_w    <= w_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/tvg_horner_cell.sv
// tvg_horner_cell: one horner step of the quarter-sine polynomial, two stages
// depends on tvg_pkg
`default_nettype none

module tvg_horner_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  tvg_pkg::side_t              in_side,
  input  tvg_pkg::q30_lanes_t         in_x,
  input  tvg_pkg::sq_lanes_t          in_x2,
  input  tvg_pkg::q30_lanes_t         in_p,
  input  logic [tvg_pkg::HMUL_W-1:0]  mul,
  input  logic [2:0]                  l,
  output logic                        out_valid,
  output tvg_pkg::side_t              out_side,
  output tvg_pkg::q30_lanes_t         out_x,
  output tvg_pkg::sq_lanes_t          out_x2,
  output tvg_pkg::q30_lanes_t         out_p
);

  logic                mid_valid;
  tvg_pkg::side_t      mid_side;
  tvg_pkg::q30_lanes_t mid_x;
  tvg_pkg::sq_lanes_t  mid_x2;
  tvg_pkg::sq_lanes_t  mid_v;

  tvg_pkg::sq_lanes_t  v_next;
  tvg_pkg::q30_lanes_t p_next;

  // rounded x2 * p in q30
  always_comb begin
    logic [62:0] prod;
    prod = '0;
    for (int i = 0; i < tvg_pkg::SINE_LANES; i++) begin
      prod      = {31'd0, in_x2[i]} * {32'd0, in_p[i]} + (63'd1 << 29);
      v_next[i] = prod[61:30];
    end
  end

  // divide by the step constant and subtract from one
  always_comb begin
    logic [64:0] prod;
    logic [64:0] shifted;
    logic [31:0] s;
    prod    = '0;
    shifted = '0;
    s       = '0;
    for (int i = 0; i < tvg_pkg::SINE_LANES; i++) begin
      prod    = {33'd0, mid_v[i]} * {32'd0, mul};
      shifted = prod >> ({4'd0, l} + 7'd32);
      s       = shifted[31:0];
      if (s > {1'b0, tvg_pkg::Q30_ONE}) begin
        p_next[i] = '0;
      end else begin
        p_next[i] = tvg_pkg::Q30_ONE - s[tvg_pkg::Q_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      mid_valid <= in_valid;
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mid_side <= in_side;
      mid_x    <= in_x;
      mid_x2   <= in_x2;
      mid_v    <= v_next;
      out_side <= mid_side;
      out_x    <= mid_x;
      out_x2   <= mid_x2;
      out_p    <= p_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/tvg_out.sv
// tvg_out: result packet register that sends its results one beat at a time
// depends on tvg_pkg and tvg_res_if
`default_nettype none

module tvg_out (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  tvg_pkg::pkt_t  in_pkt,
  output logic           take,
  tvg_res_if.source      res
);

  logic [tvg_pkg::CNT_W-1:0] cnt;
  tvg_pkg::res_arr_t         slots;
  logic                      beat;

  assign beat = res.valid && res.ready;
  assign take = (cnt == '0) || (beat && cnt == tvg_pkg::CNT_W'(1));

  assign res.valid  = (cnt != '0);
  assign res.kind   = slots[0].kind;
  assign res.comp_x = slots[0].x;
  assign res.comp_y = slots[0].y;
  assign res.comp_z = slots[0].z;
  assign res.last   = (cnt == tvg_pkg::CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (in_valid && take) begin
      cnt <= in_pkt.cnt;
    end else if (beat) begin
      cnt <= cnt - tvg_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && take) begin
      slots <= in_pkt.res;
    end else if (beat) begin
      slots <= tvg_pkg::res_arr_t'(slots >> $bits(tvg_pkg::res_t));
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/torus_vertex_generator.sv
// torus_vertex_generator: top level, config registers and arithmetic pipeline
// depends on tvg_pkg, tvg_if, tvg_div_cell, tvg_horner_cell, tvg_out
//
//   channel  dir  handshake      beat contents
//   req      in   valid/ready    req_type, ring_index, vert_index
//   res      out  valid/ready    kind, comp_x, comp_y, comp_z, last
//   cfg      in   cfg_we only    cfg_index, cfg_wdata
//
// a request reaches the result register through its pipeline stages (16-bit
// angles: 25 division cells, 2 sine front stages, 10 horner stages, 4 more)
// one result port: a vertex request gives it 5 results, a quad 2, an error 1
// the whole pipeline stalls only while the result register is full and busy
// synchronous reset clears valid flags and loads the register defaults
`default_nettype none

module torus_vertex_generator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tvg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tvg_pkg::RAD_W-1:0]     cfg_wdata,
  tvg_req_if.sink                       req,
  tvg_res_if.source                     res
);

  localparam int NDIV = tvg_pkg::DIV_W;
  localparam int NH   = tvg_pkg::HORNER_STEPS;

  logic [tvg_pkg::SEG_W-1:0] segments;
  logic [tvg_pkg::RAD_W-1:0] major_radius;
  logic [tvg_pkg::RAD_W-1:0] tube_radius;

  logic en;
  logic take;

  always_ff @(posedge clk) begin
    if (rst) begin
      segments     <= tvg_pkg::SEG_W'(48);
      major_radius <= tvg_pkg::RAD_W'(2048);
      tube_radius  <= tvg_pkg::RAD_W'(819);
    end else if (cfg_we) begin
      unique case (cfg_index)
        tvg_pkg::CFG_SEGMENTS:     segments     <= cfg_wdata[tvg_pkg::SEG_W-1:0];
        tvg_pkg::CFG_MAJOR_RADIUS: major_radius <= cfg_wdata;
        tvg_pkg::CFG_TUBE_RADIUS:  tube_radius  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // request classification
  tvg_pkg::side_t in_side;
  logic           bad;

  always_comb begin
    if (req.req_type == tvg_pkg::REQ_QUAD) begin
      bad = (req.ring_index >= segments) || (req.vert_index >= segments);
    end else begin
      bad = (req.ring_index > segments) || (req.vert_index > segments);
    end
    if (segments == '0 || int'(segments) > tvg_pkg::MAX_SEGMENTS) begin
      bad = 1'b1;
    end
    in_side      = '0;
    in_side.ring = req.ring_index;
    in_side.vert = req.vert_index;
    if (bad) begin
      in_side.cat = tvg_pkg::CAT_ERROR;
    end else if (req.req_type == tvg_pkg::REQ_QUAD) begin
      in_side.cat = tvg_pkg::CAT_QUAD;
    end else begin
      in_side.cat = tvg_pkg::CAT_VERTEX;
    end
  end

  assign req.ready = en;

  // division chain
  logic                dv_valid [NDIV+1];
  tvg_pkg::side_t      dv_side  [NDIV+1];
  tvg_pkg::rem_lanes_t dv_rem   [NDIV+1];
  tvg_pkg::w_lanes_t   dv_w     [NDIV+1];

  assign dv_valid[0] = req.valid;
  assign dv_side[0]  = in_side;
  assign dv_rem[0]   = '0;

  always_comb begin
    dv_w[0][0] = NDIV'({req.vert_index, {tvg_pkg::ANGLE_BITS{1'b0}}});
    dv_w[0][1] = NDIV'({req.ring_index, {tvg_pkg::ANGLE_BITS{1'b0}}});
    dv_w[0][2] = NDIV'({req.ring_index, 1'b0, {tvg_pkg::TEX_FRAC{1'b0}}})
               + NDIV'(segments >> 1);
    dv_w[0][3] = NDIV'({req.vert_index, {tvg_pkg::TEX_FRAC{1'b0}}})
               + NDIV'(segments >> 1);
  end

  for (genvar g = 0; g < NDIV; g++) begin : g_div
    tvg_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (dv_valid[g]),
      .in_side   (dv_side[g]),
      .in_rem    (dv_rem[g]),
      .in_w      (dv_w[g]),
      .divisor   (segments),
      .out_valid (dv_valid[g+1]),
      .out_side  (dv_side[g+1]),
      .out_rem   (dv_rem[g+1]),
      .out_w     (dv_w[g+1])
    );
  end

  // angle to quadrant and sine arguments
  tvg_pkg::side_t      f0_side;
  tvg_pkg::q30_lanes_t f0_u;

  always_comb begin
    logic [31:0] ta;
    logic [31:0] tb;
    ta = {dv_w[NDIV][0][tvg_pkg::ANGLE_BITS-1:0], {(32-tvg_pkg::ANGLE_BITS){1'b0}}};
    tb = {dv_w[NDIV][1][tvg_pkg::ANGLE_BITS-1:0], {(32-tvg_pkg::ANGLE_BITS){1'b0}}};
    f0_side       = dv_side[NDIV];
    f0_side.qa    = ta[31:30];
    f0_side.qb    = tb[31:30];
    f0_side.tex_x = dv_w[NDIV][2][tvg_pkg::TEX_X_W-1:0];
    f0_side.tex_y = dv_w[NDIV][3][tvg_pkg::TEX_Y_W-1:0];
    f0_u[0] = {1'b0, ta[29:0]};
    f0_u[1] = tvg_pkg::Q30_ONE - {1'b0, ta[29:0]};
    f0_u[2] = {1'b0, tb[29:0]};
    f0_u[3] = tvg_pkg::Q30_ONE - {1'b0, tb[29:0]};
  end

  // x = u * pi/2
  logic                f1_valid;
  tvg_pkg::side_t      f1_side;
  tvg_pkg::q30_lanes_t f1_x;
  tvg_pkg::q30_lanes_t f1_x_next;

  always_comb begin
    logic [61:0] prod;
    prod = '0;
    for (int i = 0; i < tvg_pkg::SINE_LANES; i++) begin
      prod         = {31'd0, f0_u[i]} * {31'd0, tvg_pkg::HALF_PI_Q30} + (62'd1 << 29);
      f1_x_next[i] = prod[60:30];
    end
  end

  // x2 = x * x
  logic                f2_valid;
  tvg_pkg::side_t      f2_side;
  tvg_pkg::q30_lanes_t f2_x;
  tvg_pkg::sq_lanes_t  f2_x2;
  tvg_pkg::sq_lanes_t  f2_x2_next;

  always_comb begin
    logic [61:0] prod;
    prod = '0;
    for (int i = 0; i < tvg_pkg::SINE_LANES; i++) begin
      prod          = {31'd0, f1_x[i]} * {31'd0, f1_x[i]} + (62'd1 << 29);
      f2_x2_next[i] = prod[61:30];
    end
  end

  // horner chain
  logic                h_valid [NH+1];
  tvg_pkg::side_t      h_side  [NH+1];
  tvg_pkg::q30_lanes_t h_x     [NH+1];
  tvg_pkg::sq_lanes_t  h_x2    [NH+1];
  tvg_pkg::q30_lanes_t h_p     [NH+1];

  assign h_valid[0] = f2_valid;
  assign h_side[0]  = f2_side;
  assign h_x[0]     = f2_x;
  assign h_x2[0]    = f2_x2;
  assign h_p[0]     = {tvg_pkg::SINE_LANES{tvg_pkg::Q30_ONE}};

  for (genvar g = 0; g < NH; g++) begin : g_horner
    tvg_horner_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (h_valid[g]),
      .in_side   (h_side[g]),
      .in_x      (h_x[g]),
      .in_x2     (h_x2[g]),
      .in_p      (h_p[g]),
      .mul       (tvg_pkg::HORNER_MUL[g]),
      .l         (tvg_pkg::HORNER_L[g]),
      .out_valid (h_valid[g+1]),
      .out_side  (h_side[g+1]),
      .out_x     (h_x[g+1]),
      .out_x2    (h_x2[g+1]),
      .out_p     (h_p[g+1])
    );
  end

  // final product, clamped to one
  logic                f3_valid;
  tvg_pkg::side_t      f3_side;
  tvg_pkg::q30_lanes_t f3_p;
  tvg_pkg::q30_lanes_t f3_p_next;

  always_comb begin
    logic [61:0] prod;
    prod = '0;
    for (int i = 0; i < tvg_pkg::SINE_LANES; i++) begin
      prod = {31'd0, h_x[NH][i]} * {31'd0, h_p[NH][i]} + (62'd1 << 29);
      if (prod[61:30] > {1'b0, tvg_pkg::Q30_ONE}) begin
        f3_p_next[i] = tvg_pkg::Q30_ONE;
      end else begin
        f3_p_next[i] = prod[60:30];
      end
    end
  end

  // quadrant fold and first products
  logic [tvg_pkg::Q_W-1:0] sa, ca, sb, cb;
  logic                    san, can, sbn, cbn;

  always_comb begin
    case (f3_side.qa)
      2'd0:    begin sa = f3_p[0]; san = 1'b0; ca = f3_p[1]; can = 1'b0; end
      2'd1:    begin sa = f3_p[1]; san = 1'b0; ca = f3_p[0]; can = 1'b1; end
      2'd2:    begin sa = f3_p[0]; san = 1'b1; ca = f3_p[1]; can = 1'b1; end
      default: begin sa = f3_p[1]; san = 1'b1; ca = f3_p[0]; can = 1'b0; end
    endcase
    case (f3_side.qb)
      2'd0:    begin sb = f3_p[2]; sbn = 1'b0; cb = f3_p[3]; cbn = 1'b0; end
      2'd1:    begin sb = f3_p[3]; sbn = 1'b0; cb = f3_p[2]; cbn = 1'b1; end
      2'd2:    begin sb = f3_p[2]; sbn = 1'b1; cb = f3_p[3]; cbn = 1'b1; end
      default: begin sb = f3_p[3]; sbn = 1'b1; cb = f3_p[2]; cbn = 1'b0; end
    endcase
  end

  logic [tvg_pkg::RAD_W+tvg_pkg::Q_W-1:0] rsa_prod, posy_prod;
  logic [61:0]                            nx_prod, nz_prod, tx_prod, tz_prod;
  logic [tvg_pkg::Q_W-1:0]                ca14, sb14, cb14, sa14;

  localparam int RQ_W = tvg_pkg::RAD_W + tvg_pkg::Q_W;

  always_comb begin
    rsa_prod  = RQ_W'(tube_radius) * RQ_W'(sa) + (RQ_W'(1) << 25);
    posy_prod = RQ_W'(tube_radius) * RQ_W'(ca) + (RQ_W'(1) << 25);
    nx_prod   = {31'd0, sa} * {31'd0, cb} + (62'd1 << 43);
    nz_prod   = {31'd0, sa} * {31'd0, sb} + (62'd1 << 43);
    tx_prod   = {31'd0, ca} * {31'd0, cb} + (62'd1 << 43);
    tz_prod   = {31'd0, ca} * {31'd0, sb} + (62'd1 << 43);
    ca14      = ca + 31'd8192;
    sb14      = sb + 31'd8192;
    cb14      = cb + 31'd8192;
    sa14      = sa + 31'd8192;
  end

  logic                       m1_valid;
  tvg_pkg::side_t             m1_side;
  logic [20:0]                m1_rsa;
  logic                       m1_rsan;
  logic [tvg_pkg::COMP_W-1:0] m1_posy, m1_nx, m1_ny, m1_nz, m1_sx, m1_sz;
  logic [tvg_pkg::COMP_W-1:0] m1_tx, m1_ty, m1_tz;
  logic [tvg_pkg::Q_W-1:0]    m1_sb, m1_cb;
  logic                       m1_sbn, m1_cbn;

  // d = 16 R - r sin a
  logic [22:0] d_diff;
  logic [22:0] d_abs;

  always_comb begin
    logic [22:0] rsa_tc;
    rsa_tc = m1_rsan ? (~{2'b0, m1_rsa} + 23'd1) : {2'b0, m1_rsa};
    d_diff = {3'b0, major_radius, 4'b0} - rsa_tc;
    d_abs  = d_diff[22] ? (~d_diff + 23'd1) : d_diff;
  end

  logic                       m2_valid;
  tvg_pkg::side_t             m2_side;
  logic [21:0]                m2_d;
  logic                       m2_dn;
  logic [tvg_pkg::COMP_W-1:0] m2_posy, m2_nx, m2_ny, m2_nz, m2_sx, m2_sz;
  logic [tvg_pkg::COMP_W-1:0] m2_tx, m2_ty, m2_tz;
  logic [tvg_pkg::Q_W-1:0]    m2_sb, m2_cb;
  logic                       m2_sbn, m2_cbn;

  // position x, z and packet assembly
  tvg_pkg::pkt_t pkt_next;

  always_comb begin
    logic [52:0]                px_prod;
    logic [52:0]                pz_prod;
    logic [16:0]                np1;
    logic [16:0]                a0;
    logic [16:0]                b0;
    logic [tvg_pkg::COMP_W-1:0] posx;
    logic [tvg_pkg::COMP_W-1:0] posz;
    px_prod = {31'd0, m2_d} * {22'd0, m2_cb} + (53'd1 << 29);
    pz_prod = {31'd0, m2_d} * {22'd0, m2_sb} + (53'd1 << 29);
    posx    = tvg_pkg::apply_sign(m2_dn ^ m2_cbn, 32'(px_prod[52:30]));
    posz    = tvg_pkg::apply_sign(~(m2_dn ^ m2_sbn), 32'(pz_prod[52:30]));
    np1     = 17'(segments) + 17'd1;
    a0      = 17'(m2_side.ring) * np1 + 17'(m2_side.vert);
    b0      = a0 + np1;
    pkt_next = '0;
    unique case (m2_side.cat)
      tvg_pkg::CAT_VERTEX: begin
        pkt_next.cnt    = tvg_pkg::CNT_W'(5);
        pkt_next.res[0] = '{tvg_pkg::KIND_POSITION, posx, m2_posy, posz};
        pkt_next.res[1] = '{tvg_pkg::KIND_NORMAL, m2_nx, m2_ny, m2_nz};
        pkt_next.res[2] = '{tvg_pkg::KIND_S_TANGENT, m2_sx, '0, m2_sz};
        pkt_next.res[3] = '{tvg_pkg::KIND_T_TANGENT, m2_tx, m2_ty, m2_tz};
        pkt_next.res[4] = '{tvg_pkg::KIND_TEXCOORD, 32'(m2_side.tex_x),
                            32'(m2_side.tex_y), '0};
      end
      tvg_pkg::CAT_QUAD: begin
        pkt_next.cnt    = tvg_pkg::CNT_W'(2);
        pkt_next.res[0] = '{tvg_pkg::KIND_TRIANGLE, 32'(a0), 32'(b0), 32'(a0) + 32'd1};
        pkt_next.res[1] = '{tvg_pkg::KIND_TRIANGLE, 32'(a0) + 32'd1, 32'(b0),
                            32'(b0) + 32'd1};
      end
      default: begin
        pkt_next.cnt    = tvg_pkg::CNT_W'(1);
        pkt_next.res[0] = '{tvg_pkg::KIND_ERROR, '0, '0, '0};
      end
    endcase
  end

  logic          m3_valid;
  tvg_pkg::pkt_t m3_pkt;

  assign en = take || !m3_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
      f3_valid <= 1'b0;
      m1_valid <= 1'b0;
      m2_valid <= 1'b0;
      m3_valid <= 1'b0;
    end else if (en) begin
      f1_valid <= dv_valid[NDIV];
      f2_valid <= f1_valid;
      f3_valid <= h_valid[NH];
      m1_valid <= f3_valid;
      m2_valid <= m1_valid;
      m3_valid <= m2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_side <= f0_side;
      f1_x    <= f1_x_next;
      f2_side <= f1_side;
      f2_x    <= f1_x;
      f2_x2   <= f2_x2_next;
      f3_side <= h_side[NH];
      f3_p    <= f3_p_next;

      m1_side <= f3_side;
      m1_rsa  <= rsa_prod[46:26];
      m1_rsan <= san;
      m1_posy <= tvg_pkg::apply_sign(can, 32'(posy_prod[46:26]));
      m1_nx   <= tvg_pkg::apply_sign(~(san ^ cbn), 32'(nx_prod[61:44]));
      m1_ny   <= tvg_pkg::apply_sign(can, 32'(ca14[30:14]));
      m1_nz   <= tvg_pkg::apply_sign(san ^ sbn, 32'(nz_prod[61:44]));
      m1_sx   <= tvg_pkg::apply_sign(~sbn, 32'(sb14[30:14]));
      m1_sz   <= tvg_pkg::apply_sign(~cbn, 32'(cb14[30:14]));
      m1_tx   <= tvg_pkg::apply_sign(can ^ cbn, 32'(tx_prod[61:44]));
      m1_ty   <= tvg_pkg::apply_sign(san, 32'(sa14[30:14]));
      m1_tz   <= tvg_pkg::apply_sign(~(can ^ sbn), 32'(tz_prod[61:44]));
      m1_sb   <= sb;
      m1_cb   <= cb;
      m1_sbn  <= sbn;
      m1_cbn  <= cbn;

      m2_side <= m1_side;
      m2_d    <= d_abs[21:0];
      m2_dn   <= d_diff[22];
      m2_posy <= m1_posy;
      m2_nx   <= m1_nx;
      m2_ny   <= m1_ny;
      m2_nz   <= m1_nz;
      m2_sx   <= m1_sx;
      m2_sz   <= m1_sz;
      m2_tx   <= m1_tx;
      m2_ty   <= m1_ty;
      m2_tz   <= m1_tz;
      m2_sb   <= m1_sb;
      m2_cb   <= m1_cb;
      m2_sbn  <= m1_sbn;
      m2_cbn  <= m1_cbn;

      m3_pkt  <= pkt_next;
    end
  end

  tvg_out u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (m3_valid),
    .in_pkt   (m3_pkt),
    .take     (take),
    .res      (res)
  );

endmodule

`default_nettype wire

>>> tb/sv/tb_scoreboard.sv
// tb_scoreboard: torus mesh result predictor and expected-result store
// depends on tvg_pkg; compiled after the interfaces, before tb_top
`timescale 1ns / 1ps

class torus_scoreboard;
  typedef struct {
    logic [2:0]  kind;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        last;
  } torus_res_t;

  torus_res_t pending[$];
  int unsigned segs;
  int unsigned major_r;
  int unsigned tube_r;
  int unsigned mismatches;
  int unsigned checked;

  function new();
    segs = 48;
    major_r = 2048;
    tube_r = 819;
    mismatches = 0;
    checked = 0;
  endfunction

  function void set_reg(tvg_pkg::cfg_reg_t idx, logic [15:0] val);
    case (idx)
      tvg_pkg::CFG_SEGMENTS: segs = val[7:0];
      tvg_pkg::CFG_MAJOR_RADIUS: major_r = val;
      tvg_pkg::CFG_TUBE_RADIUS: tube_r = val;
      default: ;
    endcase
  endfunction

  function longint qsine(longint unsigned u);
    longint unsigned one, x, x2, p, s, r;
    longint unsigned divs[5];
    one = 64'd1 << 30;
    divs = '{110, 72, 42, 20, 6};
    x = (u * 64'd1686629713 + (one >> 1)) >> 30;
    x2 = (x * x + (one >> 1)) >> 30;
    p = one;
    for (int k = 0; k < 5; k++) begin
      s = ((x2 * p + (one >> 1)) >> 30) / divs[k];
      p = (s > one) ? 0 : one - s;
    end
    r = (x * p + (one >> 1)) >> 30;
    if (r > one) r = one;
    return longint'(r);
  endfunction

  function void angle(longint unsigned idx, longint unsigned n,
                      output longint sn, output longint cs);
    longint unsigned p, t, f;
    longint pf, pc;
    p = ((idx << 16) / n) & 64'hFFFF;
    t = (p << 16) & 64'hFFFF_FFFF;
    f = t & ((64'd1 << 30) - 1);
    pf = qsine(f);
    pc = qsine((64'd1 << 30) - f);
    case (t >> 30)
      0: begin sn = pf; cs = pc; end
      1: begin sn = pc; cs = -pf; end
      2: begin sn = -pf; cs = -pc; end
      default: begin sn = -pc; cs = pf; end
    endcase
  endfunction

  function longint mround(longint a, longint b, int sh);
    longint unsigned ua, ub, r;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    r = (ua * ub + (64'd1 << (sh - 1))) >> sh;
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function void push(logic [2:0] k, longint x, longint y, longint z, int l);
    torus_res_t e;
    e.kind = k; e.x = x[31:0]; e.y = y[31:0]; e.z = z[31:0]; e.last = l[0];
    pending = {pending, e};
  endfunction

  function void note_request(logic quad, logic [7:0] ring, logic [7:0] vert);
    longint unsigned n, rg, vt;
    longint sa, ca, sb, cb, r, d, a0, b0;
    n = segs; rg = ring; vt = vert;
    if (n == 0 || n > tvg_pkg::MAX_SEGMENTS ||
        (quad ? (rg >= n || vt >= n) : (rg > n || vt > n))) begin
      push(tvg_pkg::KIND_ERROR, 0, 0, 0, 1);
      return;
    end
    if (quad) begin
      a0 = rg * (n + 1) + vt;
      b0 = (rg + 1) * (n + 1) + vt;
      push(tvg_pkg::KIND_TRIANGLE, a0, b0, a0 + 1, 0);
      push(tvg_pkg::KIND_TRIANGLE, a0 + 1, b0, b0 + 1, 1);
      return;
    end
    angle(vt, n, sa, ca);
    angle(rg, n, sb, cb);
    r = tube_r;
    d = longint'(major_r) * 16 - mround(r, sa, 26);
    push(tvg_pkg::KIND_POSITION, mround(d, cb, 30), mround(r, ca, 26),
         -mround(d, sb, 30), 0);
    push(tvg_pkg::KIND_NORMAL, -mround(sa, cb, 44), mround(ca, 1, 14),
         mround(sa, sb, 44), 0);
    push(tvg_pkg::KIND_S_TANGENT, -mround(sb, 1, 14), 0, -mround(cb, 1, 14), 0);
    push(tvg_pkg::KIND_T_TANGENT, mround(ca, cb, 44), mround(sa, 1, 14),
         -mround(ca, sb, 44), 0);
    push(tvg_pkg::KIND_TEXCOORD, longint'(((2 * rg << 16) + n / 2) / n),
         longint'(((vt << 16) + n / 2) / n), 0, 1);
  endfunction

  function void check_result(logic [2:0] k, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z, logic l);
    torus_res_t e;
    checked++;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result kind %0d", k);
      return;
    end
    e = pending.pop_front();
    if (e.kind !== k || e.x !== x || e.y !== y || e.z !== z || e.last !== l) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch exp k%0d %h %h %h l%0d got k%0d %h %h %h l%0d",
                 e.kind, e.x, e.y, e.z, e.last, k, x, y, z, l);
    end
  endfunction
endclass

>>> tb/sv/tb_top.sv
// tb_top: drives torus_vertex_generator with directed and random requests
// depends on tvg_pkg, tvg_if, tb_scoreboard and the rtl
`timescale 1ns / 1ps

module tb_top;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [tvg_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tvg_pkg::RAD_W-1:0] cfg_wdata = '0;
  int send_idle = 0;
  int recv_stall = 0;
  bit hold_off = 0;
  int n_sent = 0;

  tvg_req_if req();
  tvg_res_if res();
  torus_scoreboard mesh_sb = new();

  torus_vertex_generator DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .req(req), .res(res)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    req.valid <= 0; req.req_type <= 0; req.ring_index <= 0; req.vert_index <= 0;
  end

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 0;
    end else begin
      if (res.valid && res.ready)
        mesh_sb.check_result(res.kind, res.comp_x, res.comp_y, res.comp_z, res.last);
      res.ready <= !hold_off && ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic write_reg(tvg_pkg::cfg_reg_t idx, int val);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= 16'(val);
    @(posedge clk);
    cfg_we <= 0;
    mesh_sb.set_reg(idx, 16'(val));
    @(posedge clk);
  endtask

  task automatic send(int quad, int ring, int vert);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      req.valid <= 0;
      @(posedge clk);
    end
    req.valid <= 1; req.req_type <= 1'(quad);
    req.ring_index <= 8'(ring); req.vert_index <= 8'(vert);
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    mesh_sb.note_request(1'(quad), 8'(ring), 8'(vert));
    n_sent++;
  endtask

  task automatic drain();
    req.valid <= 0;
    while (mesh_sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic rand_req();
    int n;
    n = (mesh_sb.segs == 0) ? 1 : int'(mesh_sb.segs);
    if ($urandom_range(9) == 0)
      send(int'($urandom_range(1)), int'($urandom_range(255)), int'($urandom_range(255)));
    else
      send(int'($urandom_range(1)), int'($urandom_range(n)), int'($urandom_range(n)));
  endtask

  initial begin
    int idle_tab[4] = '{0, 59, 0, 17};
    int stall_tab[4] = '{0, 0, 59, 17};
    int segs_tab[4] = '{255, 1, 7, 48};
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed beats at reset settings
    send(0, 0, 0); send(0, 48, 48); send(0, 12, 36); send(0, 49, 0);
    send(0, 0, 49); send(1, 0, 0); send(1, 47, 47); send(1, 48, 0);
    send(1, 0, 48); send(0, 255, 255); send(1, 255, 255); send(0, 24, 12);
    drain();
    write_reg(tvg_pkg::CFG_SEGMENTS, 0);
    send(0, 0, 0); send(1, 0, 0);
    drain();
    write_reg(tvg_pkg::CFG_SEGMENTS, 255); write_reg(tvg_pkg::CFG_MAJOR_RADIUS, 16'hFFFF);
    write_reg(tvg_pkg::CFG_TUBE_RADIUS, 16'hFFFF);
    send(0, 255, 255); send(0, 128, 64); send(1, 254, 254); send(0, 170, 85);
    drain();
    write_reg(tvg_pkg::CFG_SEGMENTS, 1); write_reg(tvg_pkg::CFG_MAJOR_RADIUS, 0);
    write_reg(tvg_pkg::CFG_TUBE_RADIUS, 0);
    send(0, 1, 1); send(1, 0, 0); send(1, 1, 0);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = idle_tab[ph]; recv_stall = stall_tab[ph];
      write_reg(tvg_pkg::CFG_SEGMENTS, segs_tab[ph]);
      write_reg(tvg_pkg::CFG_MAJOR_RADIUS, int'($urandom_range(65535)));
      write_reg(tvg_pkg::CFG_TUBE_RADIUS, int'($urandom_range(65535)));
      for (int i = 0; i < 100; i++) rand_req();
      if (ph == 0) begin
        // long receiver hold-off while requests keep coming
        fork
          begin hold_off = 1; repeat (400) @(posedge clk); hold_off = 0; end
          for (int i = 0; i < 80; i++) rand_req();
        join
      end
      drain();
    end
    $display("covered %0d requests, %0d results over several register settings",
             n_sent, mesh_sb.checked);
    $display("including error, quad, vertex requests and long output stalls");
    if (mesh_sb.mismatches == 0 && mesh_sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #(12ns * 400000);
    $display("Test completed with failures");
    $finish;
  end
endmodule
